>>> rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, register codes and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

	// register map
	localparam int unsigned ADDR_W   = 3;
	localparam logic        REG_MODE = 1'b0;   // word index of the mode register

	// mode codes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// job queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='

	// one job: up to four results that share flags
	typedef struct packed {
		logic [1:0]      n_m1;   // number of results minus one
		logic [3:0][7:0] data;   // result bytes, entry 0 first
		logic            has;
		logic            bad;
		logic            last;   // final result of the job ends the message
	} b64_job_t;

	// decoded character
	typedef struct packed {
		logic       ok;
		logic       pad;
		logic [5:0] val;
	} b64_dec_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	// alphabet character to 6-bit value, pad mark or invalid
	function automatic b64_dec_t dec_char(input logic [7:0] c);
		b64_dec_t d;
		d = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d.ok  = 1'b1;
			d.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d.ok  = 1'b1;
			d.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d.ok  = 1'b1;
			d.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			d.ok  = 1'b1;
			d.val = 6'd62;
		end else if (c == 8'h2F) begin
			d.ok  = 1'b1;
			d.val = 6'd63;
		end else if (c == CHAR_PAD) begin
			d.ok  = 1'b1;
			d.pad = 1'b1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Takes input requests, tracks the group state and builds one job per request
// that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             mode,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output b64_pkg::b64_job_t     job,
	output logic                  job_push
);
	import b64_pkg::*;

	logic [23:0] gb_q;
	logic [1:0]  gc_q;
	logic        tip_q;
	logic        disc_q;

	logic [23:0] gb_d;
	logic [1:0]  gc_d;
	logic        tip_d;
	logic        disc_d;

	logic [1:0]  ecnt;
	logic [1:0]  ecnt1;
	logic [23:0] ebits;
	b64_dec_t    dv;
	logic [23:0] dbits;

	// classify the request and build its job
	always_comb begin
		job      = '0;
		job_push = 1'b0;
		gb_d     = gb_q;
		gc_d     = gc_q;
		tip_d    = tip_q;
		disc_d   = disc_q;
		ecnt     = (gc_q == 2'd3) ? 2'd0 : gc_q;
		ecnt1    = ecnt + 2'd1;
		ebits    = {gb_q[15:0], data_byte};
		dv       = dec_char(data_byte);
		dbits    = {gb_q[17:0], dv.val};
		if (mode == MODE_ENC) begin
			gb_d = ebits;
			gc_d = (ecnt1 == 2'd3) ? 2'd0 : ecnt1;
			job.has  = 1'b1;
			job.n_m1 = 2'd3;
			if (ecnt1 == 2'd3) begin
				// full group of three bytes
				job_push    = 1'b1;
				job.data[0] = enc_char(ebits[23:18]);
				job.data[1] = enc_char(ebits[17:12]);
				job.data[2] = enc_char(ebits[11:6]);
				job.data[3] = enc_char(ebits[5:0]);
			end else if (last_byte) begin
				// padded remainder group
				job_push = 1'b1;
				if (ecnt1 == 2'd1) begin
					job.data[0] = enc_char(data_byte[7:2]);
					job.data[1] = enc_char({data_byte[1:0], 4'd0});
					job.data[2] = CHAR_PAD;
					job.data[3] = CHAR_PAD;
				end else begin
					job.data[0] = enc_char(gb_q[7:2]);
					job.data[1] = enc_char({gb_q[1:0], data_byte[7:4]});
					job.data[2] = enc_char({data_byte[3:0], 2'd0});
					job.data[3] = CHAR_PAD;
				end
			end
			if (last_byte) begin
				job.last = 1'b1;
				gb_d     = '0;
				gc_d     = '0;
				tip_d    = 1'b0;
				disc_d   = 1'b0;
			end
		end else if (disc_q) begin
			// dropping the rest of a bad message
			if (last_byte) begin
				job_push = 1'b1;
				job.last = 1'b1;
				gb_d     = '0;
				gc_d     = '0;
				tip_d    = 1'b0;
				disc_d   = 1'b0;
			end
		end else if (!dv.ok) begin
			// character outside the alphabet
			job_push = 1'b1;
			job.bad  = 1'b1;
			job.last = last_byte;
			gb_d     = '0;
			gc_d     = '0;
			tip_d    = 1'b0;
			disc_d   = !last_byte;
		end else begin
			gb_d = dbits;
			if (gc_q == 2'd2) begin
				tip_d = dv.pad;
			end
			if (gc_q == 2'd3) begin
				// complete group of four characters
				job_push    = 1'b1;
				job.has     = 1'b1;
				job.n_m1    = {1'b0, !tip_q} + {1'b0, !dv.pad};
				job.data[0] = dbits[23:16];
				if (tip_q) begin
					job.data[1] = dbits[7:0];
				end else begin
					job.data[1] = dbits[15:8];
					job.data[2] = dbits[7:0];
				end
				gc_d  = 2'd0;
				tip_d = 1'b0;
			end else begin
				gc_d = gc_q + 2'd1;
			end
			if (last_byte) begin
				// incomplete group is dropped, a bare end marker stands in
				job_push = 1'b1;
				job.last = 1'b1;
				gb_d     = '0;
				gc_d     = '0;
				tip_d    = 1'b0;
				disc_d   = 1'b0;
			end
		end
		if (!accept) begin
			job_push = 1'b0;
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q   <= '0;
			gc_q   <= '0;
			tip_q  <= 1'b0;
			disc_q <= 1'b0;
		end else if (accept) begin
			gb_q   <= gb_d;
			gc_q   <= gc_d;
			tip_q  <= tip_d;
			disc_q <= disc_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// Short job queue that parts the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire b64_pkg::b64_job_t wr_job,
	input  wire logic              rd_en,
	output b64_pkg::b64_job_t      rd_job,
	output logic                   q_full,
	output logic                   q_valid
);
	import b64_pkg::*;

	b64_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign rd_job  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Holds the current job and hands out its results one per cycle while pop is held.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire b64_pkg::b64_job_t q_job,
	output logic                   q_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [7:0]             out_byte,
	output logic                   has_byte,
	output logic                   bad_char,
	output logic                   out_last
);
	import b64_pkg::*;

	b64_job_t   cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       take;
	logic       job_done;

	assign take     = pop && cur_valid_q;
	assign job_done = take && (idx_q == cur_q.n_m1);
	assign q_pop    = q_valid && (!cur_valid_q || job_done);

	// current result
	assign empty    = !cur_valid_q;
	assign out_byte = cur_q.has ? cur_q.data[idx_q] : 8'd0;
	assign has_byte = cur_q.has;
	assign bad_char = cur_q.bad;
	assign out_last = cur_q.last && (idx_q == cur_q.n_m1);

	// job register and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (job_done) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
	end

	// index never runs past the job
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= cur_q.n_m1)
		else $error("result index beyond job length");

	// a taken result that does not end its job moves to the next one
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !job_done) |=> (cur_valid_q && idx_q == $past(idx_q) + 2'd1))
		else $error("result index did not advance");

	// a bare marker only ends a message
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_byte && !bad_char) |-> out_last)
		else $error("bare marker without end of message");

	// the queue is drained only into a free job register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && cur_valid_q) |-> job_done)
		else $error("job loaded over a pending job");

endmodule

`default_nettype wire

>>> rtl/base64_codec.sv
// Path: the front builds the job from an accepted input request, the queue holds it,
// and the back loads it into its job register and shows it on the result ports.
// Throughput: one input request per cycle while the job queue has room, one
// result per cycle out of the back while pop is held; encode gives four results per three bytes.
// Reset: arst_n clears the mode to encode, the group state and the job queue.
// ----------------------------------------------------------------------------
// base64_codec
// Streaming base64 encoder and decoder with the standard alphabet.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_codec (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [b64_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      last_byte,
	output logic                           empty,
	input  wire logic                      pop,
	output logic      [7:0]                out_byte,
	output logic                           has_byte,
	output logic                           bad_char,
	output logic                           out_last
);
	import b64_pkg::*;

	logic     mode_q;
	logic     accept;
	b64_job_t f_job;
	logic     f_push;
	b64_job_t q_job;
	logic     q_pop;
	logic     q_valid;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	assign accept = push && !full;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.job       (f_job),
		.job_push  (f_push)
	);

	b64_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_job  (f_job),
		.rd_en   (q_pop),
		.rd_job  (q_job),
		.q_full  (full),
		.q_valid (q_valid)
	);

	b64_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.has_byte (has_byte),
		.bad_char (bad_char),
		.out_last (out_last)
	);

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_codec: a queue-driven request driver and a
// result monitor with random gaps, checked against a bit-exact codec predictor
// across encode and decode settings, bad characters, padding and mode changes.
// ----------------------------------------------------------------------------

module tb;
	import b64_pkg::*;

	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned PHASE_ITEMS    = 18;

	// symbol lookup results beyond the 64 alphabet entries
	localparam int SYM_PAD = 64;
	localparam int SYM_BAD = 65;

	localparam logic [8*64-1:0] SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
	} codec_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       bad;
		logic       eom;
	} codec_res_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [31:0]         pwdata    = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push      = 1'b0;
	logic                full;
	logic [7:0]          data_byte = 8'h00;
	logic                last_byte = 1'b0;
	logic                empty;
	logic                pop       = 1'b0;
	logic [7:0]          out_byte;
	logic                has_byte;
	logic                bad_char;
	logic                out_last;

	// request and result stores, newest at the front
	codec_req_t byte_q[$];
	codec_res_t codec_out_q[$];

	// predictor state and register copy
	logic        cfg_mode  = MODE_ENC;
	logic [23:0] grp_bits  = '0;
	logic [1:0]  grp_cnt   = '0;
	logic        third_pad = 1'b0;
	logic        dropping  = 1'b0;

	// results of the request being predicted
	logic [7:0] st_byte [4];
	logic       st_has  [4];
	logic       st_bad  [4];
	int         step_n;

	int          error_count  = 0;
	int          stall_cycles = 0;
	int          queued;
	int          hold_seq     = 0;
	int          hold_seen    = 0;
	int unsigned hold_left;
	int unsigned send_wait;
	int unsigned rcv_wait;
	bit          send_idle    = 1'b1;
	bit          recv_idle    = 1'b1;
	codec_req_t  next_req;

	base64_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.bad_char  (bad_char),
		.out_last  (out_last)
	);

	always #5 clk = ~clk;

	// alphabet symbol for a 6-bit value
	function automatic logic [7:0] sym_of(input logic [5:0] v);
		return SYMBOLS[8*(63 - int'(v)) +: 8];
	endfunction

	// 6-bit value of a character, or the pad / bad codes
	function automatic int sym_index(input logic [7:0] c);
		int i;
		if (c == CHAR_PAD)
			return SYM_PAD;
		for (i = 0; i < 64; i++)
			if (SYMBOLS[8*(63 - i) +: 8] == c)
				return i;
		return SYM_BAD;
	endfunction

	// gap before the next request or pop
	function automatic int unsigned pick_wait(input bit on);
		if (!on)
			return 0;
		case ($urandom_range(0, 2))
			0: return 0;
			1: return $urandom_range(0, 3);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic stage(input logic [7:0] ch, input logic has, input logic bad);
		st_byte[step_n] = ch;
		st_has[step_n]  = has;
		st_bad[step_n]  = bad;
		step_n++;
	endtask

	task automatic stage_group(input logic [23:0] bits, input int chars);
		int i;
		for (i = 0; i < 4; i++)
			stage((i < chars) ? sym_of(bits[23-6*i -: 6]) : CHAR_PAD, 1'b1, 1'b0);
	endtask

	task automatic clear_msg();
		grp_bits  = '0;
		grp_cnt   = '0;
		third_pad = 1'b0;
		dropping  = 1'b0;
	endtask

	// expected results of one accepted request
	task automatic codec_step(input logic [7:0] b, input logic fin);
		logic [1:0] cnt;
		int         v;
		int         i;
		codec_res_t r;
		step_n = 0;
		if (cfg_mode == MODE_ENC) begin
			// a decode group left at three counts as empty here
			cnt = (grp_cnt == 2'd3) ? 2'd0 : grp_cnt;
			grp_bits = {grp_bits[15:0], b};
			cnt = cnt + 2'd1;
			if (cnt == 2'd3) begin
				stage_group(grp_bits, 4);
				cnt = 2'd0;
			end
			if (fin) begin
				if (cnt == 2'd1)
					stage_group({grp_bits[7:0], 16'h0000}, 2);
				else if (cnt == 2'd2)
					stage_group({grp_bits[15:0], 8'h00}, 3);
				clear_msg();
			end else begin
				grp_cnt = cnt;
			end
		end else if (dropping) begin
			// rest of a bad message: only the end marker survives
			if (fin) begin
				stage(8'h00, 1'b0, 1'b0);
				clear_msg();
			end
		end else begin
			v = sym_index(b);
			if (v == SYM_BAD) begin
				stage(8'h00, 1'b0, 1'b1);
				clear_msg();
				dropping = !fin;
			end else begin
				grp_bits = {grp_bits[17:0], 6'(v)};
				if (grp_cnt == 2'd2)
					third_pad = (v == SYM_PAD);
				if (grp_cnt == 2'd3) begin
					stage(grp_bits[23:16], 1'b1, 1'b0);
					if (!third_pad)
						stage(grp_bits[15:8], 1'b1, 1'b0);
					if (v != SYM_PAD)
						stage(grp_bits[7:0], 1'b1, 1'b0);
					grp_cnt   = 2'd0;
					third_pad = 1'b0;
				end else begin
					grp_cnt = grp_cnt + 2'd1;
				end
				if (fin) begin
					if (step_n == 0)
						stage(8'h00, 1'b0, 1'b0);
					clear_msg();
				end
			end
		end
		for (i = 0; i < step_n; i++) begin
			r.ch  = st_byte[i];
			r.has = st_has[i];
			r.bad = st_bad[i];
			r.eom = fin && (i == step_n - 1);
			codec_out_q.push_front(r);
		end
	endtask

	task automatic check_result();
		codec_res_t want;
		if (codec_out_q.size() == 0) begin
			flag_error($sformatf("result byte=%h has=%b bad=%b last=%b with nothing expected",
				out_byte, has_byte, bad_char, out_last));
		end else begin
			want = codec_out_q.pop_back();
			if (out_byte !== want.ch || has_byte !== want.has ||
			    bad_char !== want.bad || out_last !== want.eom)
				flag_error($sformatf("got byte=%h has=%b bad=%b last=%b, want %h/%b/%b/%b",
					out_byte, has_byte, bad_char, out_last,
					want.ch, want.has, want.bad, want.eom));
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_wait = 0;
		end else if (!(push && full)) begin
			if (push) begin
				codec_step(data_byte, last_byte);
				send_wait = pick_wait(send_idle);
			end else if (send_wait != 0) begin
				send_wait--;
			end
			if (send_wait == 0 && byte_q.size() != 0) begin
				next_req = byte_q.pop_back();
				push      <= 1'b1;
				data_byte <= next_req.data;
				last_byte <= next_req.eom;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result monitor with random pops and the long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rcv_wait  = 0;
			hold_left = 0;
		end else begin
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (pop && !empty) begin
				check_result();
				rcv_wait = pick_wait(recv_idle);
			end else if (rcv_wait != 0) begin
				rcv_wait--;
			end
			if (hold_left != 0)
				hold_left--;
			pop <= (rcv_wait == 0) && (hold_left == 0);
		end
	end

	// cycles without any request or result moving
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("base64_codec: mismatch");
		$finish;
	end

	task automatic add_item(input logic [7:0] d, input logic fin);
		codec_req_t it;
		it.data = d;
		it.eom  = fin;
		byte_q.push_front(it);
		queued++;
	endtask

	task automatic add_text(input string s, input bit fin);
		int i;
		for (i = 0; i < s.len(); i++)
			add_item(s[i], fin && (i == s.len() - 1));
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({REG_MODE, 2'b00});
		pwdata  <= {31'b0, m};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		cfg_mode = m;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// everything sent and answered, plus the pipeline depth
	task automatic wait_drained();
		while (byte_q.size() != 0 || push || codec_out_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// random raw message for encode
	task automatic add_bytes_msg();
		int n;
		int i;
		n = $urandom_range(1, 8);
		for (i = 0; i < n; i++)
			add_item(8'($urandom_range(0, 255)), i == n - 1);
	endtask

	// mostly well-formed text for decode, some broken or noise
	task automatic add_text_msg();
		logic [7:0]  raw [8];
		logic [7:0]  txt [12];
		logic [23:0] bits;
		int          n;
		int          txt_n;
		int          rem;
		int          i;
		int          j;
		n = $urandom_range(1, 7);
		for (i = 0; i < n; i++)
			raw[i] = 8'($urandom_range(0, 255));
		txt_n = 0;
		for (i = 0; i < n; i += 3) begin
			rem  = (n - i > 3) ? 3 : n - i;
			bits = {raw[i], (rem > 1) ? raw[i+1] : 8'h00, (rem > 2) ? raw[i+2] : 8'h00};
			for (j = 0; j < 4; j++) begin
				txt[txt_n] = (j <= rem) ? sym_of(bits[23-6*j -: 6]) : CHAR_PAD;
				txt_n++;
			end
		end
		case ($urandom_range(0, 9))
			6: begin
				txt_n = $urandom_range(1, 6);
				for (i = 0; i < txt_n; i++)
					txt[i] = 8'($urandom_range(0, 255));
			end
			7: txt_n -= int'($urandom_range(1, 3));
			8: txt[$urandom_range(0, txt_n - 1)] = 8'($urandom_range(0, 255));
			9: txt[$urandom_range(0, txt_n - 1)] = CHAR_PAD;
			default: ;
		endcase
		for (i = 0; i < txt_n; i++)
			add_item(txt[i], i == txt_n - 1);
	endtask

	// stimulus sequence
	initial begin
		int p;
		bit paused;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// encode: full group, one and two byte tails, extremes
		write_mode(MODE_ENC);
		@(negedge clk);
		add_text("Man", 1'b1);
		add_item(8'h00, 1'b1);
		add_item(8'hFF, 1'b0);
		add_item(8'hFF, 1'b1);
		wait_drained();

		// decode: padding, bad characters, dropped tail, short group
		write_mode(MODE_DEC);
		@(negedge clk);
		add_text("TQ==", 1'b1);
		add_text("+/z9", 1'b0);
		add_text("TWE=", 1'b1);
		add_text("T", 1'b0);
		add_item(8'h80, 1'b0);
		add_text("Q", 1'b0);
		add_text("=", 1'b1);
		add_item(8'hFF, 1'b1);
		add_text("TW", 1'b1);
		add_text("TWF", 1'b0);
		wait_drained();

		// mode change with a decode group still held
		write_mode(MODE_ENC);
		@(negedge clk);
		add_item(8'h12, 1'b0);
		add_item(8'h34, 1'b1);
		wait_drained();

		// random phases, alternating modes
		for (p = 0; p < 6; p++) begin
			write_mode((p % 2 == 0) ? MODE_DEC : MODE_ENC);
			send_idle = (p != 2) && (p != 3);
			recv_idle = (p != 2);
			@(negedge clk);
			if (p == 3)
				hold_seq++;
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				if (cfg_mode == MODE_ENC)
					add_bytes_msg();
				else
					add_text_msg();
				if (p == 1 && !paused) begin
					paused = 1'b1;
					wait_drained();
				end
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("base64_codec: match");
		else
			$display("base64_codec: mismatch");
		$finish;
	end

endmodule
